// ===== design/lobm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types, constants and helpers of the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int PRICE_W      = 16;
    localparam int QTY_W        = 16;
    localparam int VALUE_W      = 48;
    localparam int SLOT_W_MAX   = 10;   // slot ids for books up to 1024 entries
    localparam int BOOK_DEPTH_D = 64;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // incoming order word
    typedef struct packed {
        logic               side;
        logic [PRICE_W-1:0] limit_price;
        logic [QTY_W-1:0]   order_quantity;
    } order_t;

    // result word
    typedef struct packed {
        logic [VALUE_W-1:0] traded_value_total;
        logic [QTY_W-1:0]   filled_quantity;
        logic [QTY_W-1:0]   rested_quantity;
        logic               book_overflow;
    } result_t;

    // one resting entry held in a cell
    typedef struct packed {
        logic                  valid;
        logic [PRICE_W-1:0]    price;
        logic [QTY_W-1:0]      qty;
        logic [SLOT_W_MAX-1:0] slot;
    } entry_t;

    // command from the sequencer to one book
    typedef struct packed {
        logic               pop;
        logic               upd;
        logic [QTY_W-1:0]   upd_qty;
        logic               ins;
        logic [PRICE_W-1:0] ins_price;
        logic [QTY_W-1:0]   ins_qty;
    } book_cmd_t;

    // a ranks ahead of b: best price first, then lowest slot
    function automatic logic ranks_ahead(input logic desc, input entry_t a, input entry_t b);
        logic price_better;
        price_better = desc ? (a.price > b.price) : (a.price < b.price);
        return price_better || ((a.price == b.price) && (a.slot < b.slot));
    endfunction

endpackage
`default_nettype wire

// ===== design/lobm_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lobm_cell
// One sorted-chain cell: holds an entry, shifts toward the head on a pop,
// opens a gap for a sorted insert, and updates quantity at the head.
// ----------------------------------------------------------------------------
module lobm_cell
    import lobm_pkg::*;
#(
    parameter bit DESC    = 1'b0,
    parameter bit IS_HEAD = 1'b0
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire book_cmd_t cmd,
    input  wire entry_t    new_e,
    input  wire entry_t    left_e,
    input  wire logic      left_ins,
    input  wire entry_t    right_e,
    output entry_t         e,
    output logic           ins_here
);

    entry_t e_reg, e_next;

    assign e = e_reg;

    // new entry belongs at or ahead of this cell
    assign ins_here = !e_reg.valid || ranks_ahead(DESC, new_e, e_reg);

    always_comb
    begin
        e_next = e_reg;
        if (cmd.pop)
        begin
            e_next = right_e;
        end
        else if (cmd.upd && IS_HEAD)
        begin
            e_next.qty = cmd.upd_qty;
        end
        else if (cmd.ins && ins_here)
        begin
            e_next = left_ins ? left_e : new_e;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_reg <= '0;
        end
        else
        begin
            e_reg <= e_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/lobm_book.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lobm_book
// One side of the book: a sorted chain of cells with the best entry at the
// head, plus the slot-occupancy map that picks the lowest free slot.
// ----------------------------------------------------------------------------
module lobm_book
    import lobm_pkg::*;
#(
    parameter int BOOK_DEPTH = BOOK_DEPTH_D,
    parameter bit DESC       = 1'b0
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire book_cmd_t cmd,
    output entry_t         head,
    output logic           full
);

    localparam int SW = $clog2(BOOK_DEPTH);

    entry_t                ent   [BOOK_DEPTH];
    logic [BOOK_DEPTH-1:0] ins_v;
    logic [BOOK_DEPTH-1:0] used_reg, used_next;
    logic [SW-1:0]         free_slot;
    entry_t                new_e;

    // lowest free slot
    always_comb
    begin
        free_slot = '0;
        for (int i = BOOK_DEPTH - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = SW'(i);
            end
        end
    end

    assign full = &used_reg;
    assign head = ent[0];

    always_comb
    begin
        new_e       = '0;
        new_e.valid = 1'b1;
        new_e.price = cmd.ins_price;
        new_e.qty   = cmd.ins_qty;
        new_e.slot  = SLOT_W_MAX'(free_slot);
    end

    // occupancy map
    always_comb
    begin
        used_next = used_reg;
        if (cmd.pop)
        begin
            used_next[ent[0].slot[SW-1:0]] = 1'b0;
        end
        else if (cmd.ins)
        begin
            used_next[free_slot] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    // cell chain
    for (genvar g = 0; g < BOOK_DEPTH; g++)
    begin : g_cell
        entry_t lft, rgt;
        logic   lft_ins;
        if (g == 0)
        begin : g_first
            assign lft     = '0;
            assign lft_ins = 1'b0;
        end
        else
        begin : g_mid
            assign lft     = ent[g-1];
            assign lft_ins = ins_v[g-1];
        end
        if (g == BOOK_DEPTH - 1)
        begin : g_last
            assign rgt = '0;
        end
        else
        begin : g_rest
            assign rgt = ent[g+1];
        end

        lobm_cell #(
            .DESC    (DESC),
            .IS_HEAD (g == 0)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .new_e    (new_e),
            .left_e   (lft),
            .left_ins (lft_ins),
            .right_e  (rgt),
            .e        (ent[g]),
            .ins_here (ins_v[g])
        );
    end

endmodule
`default_nettype wire

// ===== design/limit_order_book_matcher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Matches limit orders against sorted bid and ask cell chains.
//
//   channel | direction | handshake          | word
//   req     | in        | req_valid/req_stall | order_t
//   rsp     | out       | rsp_valid/rsp_stall | result_t
//
// The result word of an order is registered in ST_DONE, after ST_MATCH has
// filled resting entries and ST_REST has rested any remainder; one entry is
// consumed per cycle at the head of the opposite chain. The next order is
// taken once the sequencer is back in ST_IDLE.
// Reset clears both books and the traded value at once; no clearing pass.
// A new order is taken while the previous result still waits in rsp;
// a held rsp only delays the end of the following order.
// ----------------------------------------------------------------------------
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int BOOK_DEPTH = BOOK_DEPTH_D
)(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_stall,
    input  wire order_t  req,
    output logic         rsp_valid,
    input  wire logic    rsp_stall,
    output result_t      rsp
);

    typedef enum logic [1:0] {ST_IDLE, ST_MATCH, ST_REST, ST_DONE} state_t;

    state_t             state_reg;
    logic               side_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [QTY_W-1:0]   rem_reg;
    logic [QTY_W-1:0]   filled_reg;
    logic [QTY_W-1:0]   rested_reg;
    logic               ovf_reg;
    logic [VALUE_W-1:0] acc_reg;
    logic [31:0]        prod_reg;
    logic               add_reg;
    logic               rsp_valid_reg;
    result_t            rsp_reg;

    book_cmd_t bid_cmd, ask_cmd, opp_cmd, own_cmd;
    entry_t    bid_head, ask_head, opp_head;
    logic      bid_full, ask_full, own_full;
    logic      elig;
    logic [QTY_W-1:0] fill;
    logic [VALUE_W:0] sum;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    lobm_book #(.BOOK_DEPTH(BOOK_DEPTH), .DESC(1'b1)) u_bid (
        .clk(clk), .rst_n(rst_n), .cmd(bid_cmd), .head(bid_head), .full(bid_full)
    );
    lobm_book #(.BOOK_DEPTH(BOOK_DEPTH), .DESC(1'b0)) u_ask (
        .clk(clk), .rst_n(rst_n), .cmd(ask_cmd), .head(ask_head), .full(ask_full)
    );

    // head of the opposite book and its eligibility
    assign opp_head = (side_reg == SIDE_SELL) ? bid_head : ask_head;
    assign own_full = (side_reg == SIDE_SELL) ? ask_full : bid_full;
    assign elig = opp_head.valid && (rem_reg != '0) &&
                  ((side_reg == SIDE_SELL) ? (opp_head.price >= price_reg)
                                           : (opp_head.price <= price_reg));
    assign fill = (opp_head.qty < rem_reg) ? opp_head.qty : rem_reg;

    // book commands
    always_comb
    begin
        opp_cmd = '0;
        own_cmd = '0;
        if (state_reg == ST_MATCH && elig)
        begin
            opp_cmd.pop     = (opp_head.qty == fill);
            opp_cmd.upd     = (opp_head.qty != fill);
            opp_cmd.upd_qty = opp_head.qty - fill;
        end
        if (state_reg == ST_REST && rem_reg != '0 && !own_full)
        begin
            own_cmd.ins       = 1'b1;
            own_cmd.ins_price = price_reg;
            own_cmd.ins_qty   = rem_reg;
        end
        bid_cmd = (side_reg == SIDE_SELL) ? opp_cmd : own_cmd;
        ask_cmd = (side_reg == SIDE_SELL) ? own_cmd : opp_cmd;
    end

    assign sum = {1'b0, acc_reg} + {{(VALUE_W - 31){1'b0}}, prod_reg};

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            add_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // result valid: set when loaded, cleared once taken
            if (state_reg == ST_DONE && (!rsp_valid_reg || !rsp_stall))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            // saturating accumulate, in the cycle after each fill
            if (add_reg)
            begin
                acc_reg <= sum[VALUE_W] ? {VALUE_W{1'b1}} : sum[VALUE_W-1:0];
            end
            add_reg <= (state_reg == ST_MATCH) && elig;

            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        side_reg   <= req.side;
                        price_reg  <= req.limit_price;
                        rem_reg    <= req.order_quantity;
                        filled_reg <= '0;
                        state_reg  <= ST_MATCH;
                    end
                end
                ST_MATCH:
                begin
                    if (elig)
                    begin
                        prod_reg   <= 32'(price_reg) * 32'(fill);
                        rem_reg    <= rem_reg - fill;
                        filled_reg <= filled_reg + fill;
                    end
                    else
                    begin
                        state_reg <= ST_REST;
                    end
                end
                ST_REST:
                begin
                    rested_reg <= (rem_reg != '0 && !own_full) ? rem_reg : '0;
                    ovf_reg    <= (rem_reg != '0 && own_full);
                    state_reg  <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg.traded_value_total <= acc_reg;
                        rsp_reg.filled_quantity    <= filled_reg;
                        rsp_reg.rested_quantity    <= rested_reg;
                        rsp_reg.book_overflow      <= ovf_reg;
                        state_reg                  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
